// ===== sv/sha256_pkg.sv =====
package sha256_pkg;

  typedef logic [31:0] word_t;

  // Round constants
  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    begin
      k = '0;
      case (idx)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  // Initial hash values
  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    begin
      h = '0;
      case (idx)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

endpackage

// ===== sv/sha256_stream_hasher.sv =====
// Byte-serial SHA-256. Byte items are taken one per cycle while in_stall is low; the
// 64th byte of a block stalls the input while the block is loaded, run through
// its rounds and added into the chain words. Closing pads one byte per cycle up to
// byte 63 of each padded block, then the eight digest words leave in index order,
// held while the receiver stalls.
// Reset (synchronous, rst_n low) clears counters and selects the initial hash.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  state_r;
  logic [6:0]  cnt_r;       // load, round and chain update counter
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [63:0] bits_r;
  logic        closing_r;
  logic        padded_r;    // 0x80 already written
  logic        len_blk_r;   // current pad block carries the length
  logic        first_blk_r; // chain memory stale, use initial hash
  logic [2:0]  ord_r;
  logic        rdy_r;

  // Chaining words and block bytes
  logic [31:0] chain_mem [8];
  logic [31:0] chain_q;
  logic [7:0]  blk_mem [64];
  logic [7:0]  blk_q;

  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  // Schedule window, oldest word at index 0
  logic [31:0] w_r [16];

  logic        in_acc;
  logic        bw_en;
  logic [7:0]  bw_data;
  logic [5:0]  blk_ra;
  logic [2:0]  ch_ra;
  logic        ch_we;
  logic [2:0]  ch_wa;
  logic [31:0] ch_wd;
  logic [31:0] init_word;
  logic [31:0] chain_base;
  logic [31:0] w_cur, t1, t2, s0, s1;
  logic [31:0] x15, x2;
  logic        out_load;
  logic        ov_r;
  logic [31:0] od_r;
  logic [2:0]  oi_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Byte write path shared by input and padding
  always_comb begin
    bw_en = 1'b0;
    bw_data = in_data_byte;
    if (in_acc && in_has_byte) bw_en = 1'b1;
    else if (state_r == ST_PAD) begin
      bw_en = 1'b1;
      if (!padded_r) bw_data = sha256_pkg::PAD_BYTE;
      else if (len_blk_r && fill_r >= sha256_pkg::LEN_POS)
        bw_data = bits_r[{3'd7 - fill_r[2:0], 3'b000} +: 8];
      else bw_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (bw_en) blk_mem[fill_r] <= bw_data;
    blk_q <= blk_mem[blk_ra];
  end

  // Round logic
  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    x15 = w_r[1];
    x2  = w_r[14];
    s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    if (cnt_r < 7'd16) w_cur = w_r[0];
    else w_cur = w_r[0] + s0 + w_r[9] + s1;
    t1 = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) +
         ((e_r & f_r) ^ (~e_r & g_r)) + sha256_pkg::round_k(cnt_r[5:0]) + w_cur;
    t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) +
         ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  // Memory addresses and chain write-back
  always_comb begin
    blk_ra     = cnt_r[5:0];
    ch_ra      = (state_r == ST_OUT) ? ord_r : cnt_r[2:0];
    init_word  = sha256_pkg::init_h(cnt_r[2:0] - 3'd1);
    chain_base = first_blk_r ? init_word : chain_q;
    ch_we      = (state_r == ST_ADD) && (cnt_r != 7'd0);
    ch_wa      = cnt_r[2:0] - 3'd1;
    ch_wd      = chain_base + a_r;
  end

  always_ff @(posedge clk) begin
    chain_q <= chain_mem[ch_ra];
    if (ch_we) chain_mem[ch_wa] <= ch_wd;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; fill_r <= '0; len_r <= '0; bits_r <= '0;
      closing_r <= 1'b0; padded_r <= 1'b0; len_blk_r <= 1'b0;
      first_blk_r <= 1'b1; ord_r <= '0; rdy_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_has_byte) begin
              fill_r <= fill_r + 6'd1;
              len_r  <= len_r + 64'd1;
            end
            if (in_end_of_message) begin
              closing_r <= 1'b1;
              padded_r <= 1'b0;
              bits_r <= (len_r + {63'd0, in_has_byte}) << 3;
            end
            if (in_has_byte && fill_r == 6'd63) begin
              state_r <= ST_LOAD; cnt_r <= '0;
            end else if (in_end_of_message) state_r <= ST_PAD;
          end
        end
        ST_PAD: begin
          fill_r <= fill_r + 6'd1;
          if (!padded_r) begin
            padded_r <= 1'b1;
            len_blk_r <= (fill_r < sha256_pkg::LEN_POS);
          end
          if (fill_r == 6'd63) begin
            state_r <= ST_LOAD; cnt_r <= '0;
          end
        end
        ST_LOAD: begin
          if (cnt_r == 7'd64) begin
            state_r <= ST_RND; cnt_r <= '0;
          end else cnt_r <= cnt_r + 7'd1;
        end
        ST_RND: begin
          if (cnt_r == 7'd63) begin
            state_r <= ST_ADD; cnt_r <= '0;
          end else cnt_r <= cnt_r + 7'd1;
        end
        ST_ADD: begin
          if (cnt_r == 7'd8) begin
            cnt_r <= '0;
            first_blk_r <= 1'b0;
            if (!closing_r) state_r <= ST_IDLE;
            else if (padded_r && len_blk_r) begin
              state_r <= ST_OUT; ord_r <= '0; rdy_r <= 1'b0;
            end else begin
              // padding not started or length did not fit, one more pad block
              state_r <= ST_PAD;
              if (padded_r) len_blk_r <= 1'b1;
            end
          end else cnt_r <= cnt_r + 7'd1;
        end
        ST_OUT: begin
          if (!rdy_r) rdy_r <= 1'b1;
          else if (out_load) begin
            rdy_r <= 1'b0;
            ord_r <= ord_r + 3'd1;
            if (ord_r == 3'd7) begin
              state_r <= ST_IDLE;
              closing_r <= 1'b0; len_r <= '0; first_blk_r <= 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      if (cnt_r != 7'd0) begin
        for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
        w_r[15] <= {w_r[15][23:0], blk_q};
      end
      if (cnt_r != 7'd0 && cnt_r < 7'd9) begin
        h_r <= chain_base; g_r <= h_r; f_r <= g_r; e_r <= f_r;
        d_r <= e_r; c_r <= d_r; b_r <= c_r; a_r <= b_r;
      end
    end else if (state_r == ST_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end else if (state_r == ST_ADD && cnt_r != 7'd0) begin
      // rotate so a_r holds the word being added back
      a_r <= b_r; b_r <= c_r; c_r <= d_r; d_r <= e_r;
      e_r <= f_r; f_r <= g_r; g_r <= h_r;
    end
  end

  // Digest output register
  assign out_load = (state_r == ST_OUT) && rdy_r && (!ov_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; od_r <= '0; oi_r <= '0;
    end else if (out_load) begin
      ov_r <= 1'b1; od_r <= chain_q; oi_r <= ord_r;
    end else if (!out_stall) ov_r <= 1'b0;
  end

  assign out_valid = ov_r;
  assign out_digest_word = od_r;
  assign out_word_index = oi_r;
  assign out_last_word = (oi_r == 3'd7);

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digest_word) &&
    $stable(out_word_index))) else $error("stalled output changed");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_word) |-> (out_word_index == 3'd7)) else $error("last");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |-> (fill_r == 6'd0)) else $error("fill during rounds");

endmodule

// ===== sim/sha256_digest_checker.sv =====
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  sha256_pkg::word_t chain [8];
  logic [7:0]   block_buf [64];
  int           fill;
  logic [63:0]  byte_total;
  digest_word_t digest_q [$];

  function automatic sha256_pkg::word_t rotr(sha256_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Own copy of the round constants and initial values (FIPS 180-4)
  localparam sha256_pkg::word_t ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam sha256_pkg::word_t START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  task automatic compress();
    sha256_pkg::word_t w [64];
    sha256_pkg::word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    for (int r = 16; r < 64; r++)
      w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
             + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[r] + w[r];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic append_byte(logic [7:0] v);
    block_buf[fill] = v;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
    fill = 0;
    byte_total = '0;
  endtask

  // Model one accepted input item; a close queues the eight digest words
  task automatic absorb_item(logic [7:0] data, logic has_byte, logic close);
    logic [63:0] bit_len;
    digest_word_t dw;
    if (has_byte) begin
      byte_total++;
      append_byte(data);
    end
    if (close) begin
      bit_len = byte_total << 3;
      append_byte(8'h80);
      while (fill != 56) append_byte(8'h00);
      for (int i = 7; i >= 0; i--) append_byte(bit_len[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.word  = chain[i];
        dw.index = 3'(i);
        dw.last  = (i == 7);
        digest_q.push_back(dw);
      end
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    words_pending = 0;
    restart_message();
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        absorb_item(in_data_byte, in_has_byte, in_end_of_message);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word: got word=%h index=%0d last=%0b",
                   $time, out_digest_word, out_word_index, out_last_word);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word || out_word_index !== want.index ||
              out_last_word !== want.last) begin
            $display("%0t: digest word mismatch: expected word=%h index=%0d last=%0b,",
                     $time, want.word, want.index, want.last);
            $display("%0t:   got word=%h index=%0d last=%0b",
                     $time, out_digest_word, out_word_index, out_last_word);
            fail_count++;
          end
        end
      end
    end
    words_pending = digest_q.size();
  end
endmodule

// ===== sim/sha256_stream_hasher_tb.sv =====
module sha256_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  int          fail_count;
  int          words_pending;
  int          cycle_count;
  bit          hold_off_req;
  bit          stall_enable;

  sha256_stream_hasher uut (.*);

  sha256_digest_checker checker_i (.*);

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sha256_stream_hasher: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure: random pattern, plus one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        n = 0;
        while (n < 300) begin
          @(negedge clk);
          n++;
        end
        hold_off_req = 1'b0;
        out_stall = 1'b0;
      end else if (stall_enable)
        out_stall = ($urandom_range(0, 3) == 0);
      else
        out_stall = 1'b0;
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(logic [7:0] data, logic has_byte, logic close);
    in_valid = 1'b1;
    in_data_byte = data;
    in_has_byte = has_byte;
    in_end_of_message = close;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    in_data_byte = 8'($urandom);
  endtask

  // Random idle gap after an item, bursts of back-to-back items between
  int burst_left;
  task automatic maybe_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic send_message(int len, bit empty_close);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
        maybe_gap();
      end
      send_item(8'($urandom), 1'b1, (!empty_close && i == len - 1));
      maybe_gap();
    end
    if (empty_close || len == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
      maybe_gap();
    end
  endtask

  initial begin
    int len;
    cycle_count = 0;
    hold_off_req = 1'b0;
    stall_enable = 1'b0;
    burst_left = 0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_has_byte = 1'b0;
    in_end_of_message = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty message, byte extremes, ignored items, 55/56 byte pad edges
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'haa, 1'b1, 1'b1);
    stall_enable = 1'b1;
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b1);

    // Long receiver hold-off while the sender keeps offering
    hold_off_req = 1'b1;
    send_message(20, 1'b0);
    send_message(3, 1'b0);
    send_message(2, 1'b1);

    // Random messages, mostly short
    for (int m = 0; m < 6; m++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(57, 70) : $urandom_range(0, 12);
      send_message(len, $urandom_range(0, 1));
    end

    // Drain
    while (words_pending != 0 || hold_off_req) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("** sha256_stream_hasher: PASSED **");
    else
      $display("** sha256_stream_hasher: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/sha256_pkg.sv
sv/sha256_stream_hasher.sv
sim/sha256_digest_checker.sv
sim/sha256_stream_hasher_tb.sv
